[rtl/tlpf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_pkg: shared types and codes of the three-level priority FIFO
// Field widths, command codes and the command passed from front to back.
// ----------------------------------------------------------------------------
package tlpf_pkg;

  localparam int unsigned PAYLOAD_W  = 32;
  localparam int unsigned LEVEL_W    = 2;
  localparam int unsigned NUM_LEVELS = 3;

  localparam logic MODE_SEND = 1'b0;
  localparam logic MODE_RECV = 1'b1;

  localparam logic [LEVEL_W-1:0] LVL_HIGH    = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_MEDIUM  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_LOW     = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_INVALID = 2'd3;

  typedef struct packed {
    logic                 recv;
    logic                 lvl_ok;
    logic [LEVEL_W-1:0]   level;
    logic [PAYLOAD_W-1:0] payload;
  } tlpf_cmd_t;

endpackage
`default_nettype wire

[rtl/tlpf_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_if: command and response channels
// Valid/ready channels carrying the request and result fields.
// ----------------------------------------------------------------------------
interface tlpf_cmd_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  level;
  logic [31:0] payload;

  modport source (output valid, output mode, output level, output payload, input ready);
  modport sink   (input valid, input mode, input level, input payload, output ready);
endinterface

interface tlpf_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic        dropped_oldest;
  logic [31:0] out_payload;
  logic [1:0]  out_level;
  logic        all_empty;
  logic        all_full;

  modport source (output valid, output ok, output dropped_oldest, output out_payload,
                  output out_level, output all_empty, output all_full, input ready);
  modport sink   (input valid, input ok, input dropped_oldest, input out_payload,
                  input out_level, input all_empty, input all_full, output ready);
endinterface
`default_nettype wire

[rtl/tlpf_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_front: command intake
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tlpf_front
  import tlpf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  tlpf_cmd_if.sink       cmd_i,
  output     logic       cmd_valid_o,
  output     tlpf_cmd_t  cmd_o,
  input  wire logic      cmd_ready_i
);

  localparam int unsigned QD = 2;
  localparam int unsigned PW = $clog2(QD);
  localparam int unsigned CW = $clog2(QD + 1);

  tlpf_cmd_t       buf_q [QD];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;
  tlpf_cmd_t       cls;

  always_comb begin
    cls.recv    = (cmd_i.mode == MODE_RECV);
    cls.lvl_ok  = (cmd_i.level != LVL_INVALID);
    cls.level   = cmd_i.level;
    cls.payload = cmd_i.payload;
  end

  assign cmd_i.ready = (cnt_q != CW'(QD));
  assign push        = cmd_i.valid && cmd_i.ready;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= cls;
    end
  end

endmodule
`default_nettype wire

[rtl/tlpf_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlpf_back: FIFO storage and execution
// Keeps the three FIFOs, executes one command at a time and registers the
// result.
// ----------------------------------------------------------------------------
module tlpf_back
  import tlpf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cmd_valid_i,
  input  wire tlpf_cmd_t cmd_i,
  output     logic       cmd_ready_o,
  tlpf_rsp_if.source     rsp_o
);

  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [PAYLOAD_BITS-1:0] mem_q [NUM_LEVELS][QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] rdata_q;

  logic [IW-1:0]  ridx_q [NUM_LEVELS];
  logic [CW-1:0]  fill_q [NUM_LEVELS];
  logic [IW-1:0]  ridx_d [NUM_LEVELS];
  logic [CW-1:0]  fill_d [NUM_LEVELS];
  logic [IW-1:0]  rinc   [NUM_LEVELS];
  logic [IW-1:0]  wpos   [NUM_LEVELS];
  logic [CW:0]    wsum   [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] nonempty, full, pick, send_hit, recv_hit;

  logic               exec, send_ok, recv_ok, drop;
  logic               empty_after, full_after;
  logic [IW-1:0]      waddr, raddr;
  logic [LEVEL_W-1:0] rlvl;

  logic                 out_valid_q, rd_pend_q;
  logic                 ok_q, drop_q, aempty_q, afull_q;
  logic [LEVEL_W-1:0]   lvl_q;
  logic [PAYLOAD_W-1:0] pay_q;

  assign cmd_ready_o = !rd_pend_q && (!out_valid_q || rsp_o.ready);
  assign exec        = cmd_valid_i && cmd_ready_o;
  assign send_ok     = !cmd_i.recv && cmd_i.lvl_ok;
  assign recv_ok     = cmd_i.recv && (nonempty != '0);

  always_comb begin
    for (int l = 0; l < NUM_LEVELS; l++) begin
      nonempty[l] = (fill_q[l] != '0);
    end
    pick[0] = nonempty[0];
    pick[1] = !nonempty[0] && nonempty[1];
    pick[2] = !nonempty[0] && !nonempty[1] && nonempty[2];
  end

  always_comb begin
    drop        = 1'b0;
    waddr       = '0;
    raddr       = '0;
    rlvl        = '0;
    empty_after = 1'b1;
    full_after  = 1'b1;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      full[l]     = (fill_q[l] == CW'(QUEUE_DEPTH));
      rinc[l]     = (ridx_q[l] == IW'(QUEUE_DEPTH - 1)) ? '0 : ridx_q[l] + IW'(1);
      wsum[l]     = (CW+1)'(ridx_q[l]) + (CW+1)'(fill_q[l]);
      if (wsum[l] >= (CW+1)'(QUEUE_DEPTH)) begin
        wsum[l] = wsum[l] - (CW+1)'(QUEUE_DEPTH);
      end
      wpos[l]     = full[l] ? ridx_q[l] : wsum[l][IW-1:0];
      send_hit[l] = exec && send_ok && (cmd_i.level == LEVEL_W'(l));
      recv_hit[l] = exec && recv_ok && pick[l];

      ridx_d[l] = ridx_q[l];
      fill_d[l] = fill_q[l];
      if (send_hit[l]) begin
        if (full[l]) begin
          ridx_d[l] = rinc[l];
        end else begin
          fill_d[l] = fill_q[l] + CW'(1);
        end
      end else if (recv_hit[l]) begin
        ridx_d[l] = rinc[l];
        fill_d[l] = fill_q[l] - CW'(1);
      end

      drop  = drop | (send_hit[l] && full[l]);
      waddr = waddr | (send_hit[l] ? wpos[l] : '0);
      raddr = raddr | (recv_hit[l] ? ridx_q[l] : '0);
      rlvl  = rlvl | (recv_hit[l] ? LEVEL_W'(l) : '0);
      empty_after = empty_after && (fill_d[l] == '0);
      full_after  = full_after && (fill_d[l] == CW'(QUEUE_DEPTH));
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec && send_ok) begin
      mem_q[cmd_i.level][waddr] <= PAYLOAD_BITS'(cmd_i.payload);
    end
    if (exec && recv_ok) begin
      rdata_q <= mem_q[rlvl][raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        ridx_q[l] <= '0;
        fill_q[l] <= '0;
      end
      out_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        ridx_q[l] <= ridx_d[l];
        fill_q[l] <= fill_d[l];
      end
      if (exec && recv_ok) begin
        rd_pend_q   <= 1'b1;
        out_valid_q <= 1'b0;
      end else if (exec) begin
        out_valid_q <= 1'b1;
      end else if (rd_pend_q) begin
        rd_pend_q   <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      ok_q     <= send_ok || recv_ok;
      drop_q   <= drop;
      lvl_q    <= rlvl;
      aempty_q <= empty_after;
      afull_q  <= full_after;
      pay_q    <= '0;
    end else if (rd_pend_q) begin
      pay_q    <= PAYLOAD_W'(rdata_q);
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.ok             = ok_q;
  assign rsp_o.dropped_oldest = drop_q;
  assign rsp_o.out_payload    = pay_q;
  assign rsp_o.out_level      = lvl_q;
  assign rsp_o.all_empty      = aempty_q;
  assign rsp_o.all_full       = afull_q;

endmodule
`default_nettype wire

[rtl/three_level_priority_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// three_level_priority_fifo: strict-priority queue over three FIFOs
// Sends append to the FIFO of their level, dropping its oldest entry when
// full; receives pop the highest-priority non-empty FIFO.
//
//   Channel  Direction  Transfer moves
//   cmd_i    in         mode, level, payload
//   rsp_o    out        ok, dropped_oldest, out_payload, out_level,
//                       all_empty, all_full
//
// A successful receive holds the execution stage until the registered read of
// the FIFO storage returns; a send leaves it free again after it executes.
// A send or a failed receive passes through the command queue and the result
// registers; a successful receive also passes through the read data register.
// Reset clears the pointers and fill counts at once; no clearing pass.
// A two-entry command queue accepts until full while a result is held back.
// ----------------------------------------------------------------------------
module three_level_priority_fifo
  import tlpf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tlpf_cmd_if.sink   cmd_i,
  tlpf_rsp_if.source rsp_o
);

  logic      cmd_valid;
  logic      cmd_ready;
  tlpf_cmd_t cmd;

  tlpf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  tlpf_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .rsp_o       (rsp_o)
  );

`ifndef SYNTHESIS
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ok |-> rsp_o.out_payload == '0 && !rsp_o.dropped_oldest)
    else $error("Failed result carries data or a drop flag.");

  a_empty_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.all_empty && rsp_o.all_full))
    else $error("Result reports empty and full together.");

  a_drop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.dropped_oldest |-> rsp_o.ok && rsp_o.out_level == LVL_HIGH)
    else $error("Drop flagged on a result that is not a send.");

  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> rsp_o.out_level != LVL_INVALID)
    else $error("Result level out of range.");
`endif

endmodule
`default_nettype wire
